FILE: hdl/eamc_pkg.sv
// shared types, constants and month table for the easter and month weekday calculator
package eamc_pkg;

  localparam logic [15:0] YEAR_LOW  = 16'd1583;
  localparam logic [15:0] YEAR_HIGH = 16'd4099;
  localparam logic [3:0]  MONTHS    = 4'd12;
  localparam logic [2:0]  MONTH_MAR = 3'd3;
  localparam logic [2:0]  MONTH_APR = 3'd4;

  localparam logic [4:0] BASE_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // year summary handed from the date pipeline to the month sequencer
  typedef struct packed {
    logic       err;
    logic       leap;
    logic [2:0] emon;
    logic [4:0] eday;
    logic [2:0] wd;
  } eamc_year_t;

  // days in month m (1 is january), february gets the leap day
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    begin
      if (m >= 4'd1 && m <= MONTHS) begin
        len = BASE_LEN[m - 4'd1];
      end else begin
        len = 5'd31;
      end
      if (m == 4'd2 && leap) begin
        len = 5'd29;
      end
      return len;
    end
  endfunction

endpackage

FILE: hdl/easter_and_month_weekday_calc.sv
// top level of the easter and month weekday calculator
//
// input channel: year with in_valid / in_stall, one year per item.
// output channel: out_valid / out_stall with one item per month, january to
// december, each carrying month_number, first_weekday, month_length, the
// easter date, leap_year, range_error and last_month (set on december).
// years outside 1583 to 4099 still give twelve items, with range_error set
// and every other field zero.
// path: seven pipeline stages then the month register, which takes the year
// and presents its january item once it has finished the year before.
// output rate: one month per cycle while out_stall is low, so each year
// holds the output port for twelve items; the date pipeline holds up to seven
// further years meanwhile and keeps taking items until it fills.
// reset clears all valid bits; nothing else needs clearing.
// a stalled output holds its item; the pipeline then fills and in_stall rises
// once every stage is occupied.
module easter_and_month_weekday_calc import eamc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] year,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  month_number,
  output logic [2:0]  first_weekday,
  output logic [4:0]  month_length,
  output logic [2:0]  easter_month,
  output logic [4:0]  easter_day,
  output logic        leap_year,
  output logic        range_error,
  output logic        last_month
);

  logic       res_valid;
  logic       res_take;
  eamc_year_t res;

  eamc_date_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .year      (year),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  eamc_month_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res           (res),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .month_number  (month_number),
    .first_weekday (first_weekday),
    .month_length  (month_length),
    .easter_month  (easter_month),
    .easter_day    (easter_day),
    .leap_year     (leap_year),
    .range_error   (range_error),
    .last_month    (last_month)
  );

endmodule

FILE: hdl/eamc_date_pipe.sv
// seven stage pipeline computing easter date, leap flag and weekday of 1 january
module eamc_date_pipe import eamc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] year,
  output logic        res_valid,
  input  logic        res_take,
  output eamc_year_t  res
);

  logic [6:0] v;
  logic [6:0] en;

  always_comb begin
    en[6] = !v[6] || res_take;
    for (int i = 5; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_stall  = !en[0];
  assign res_valid = v[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int i = 1; i < 7; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  // stage 1: quotients by 19 and by 100 through reciprocal products
  logic [12:0] y13;
  logic [26:0] p19, p100;
  logic [12:0] y1;
  logic [7:0]  q19_1;
  logic [6:0]  q100_1;
  logic        err1;

  assign y13  = year[12:0];
  assign p19  = 27'(y13) * 27'd13798;
  assign p100 = 27'(y13) * 27'd5243;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      y1     <= y13;
      q19_1  <= p19[25:18];
      q100_1 <= p100[25:19];
      err1   <= (year < YEAR_LOW) || (year > YEAR_HIGH);
    end
  end

  // stage 2: golden number, century terms, leap rule
  logic [12:0] m19, m100, rem19, rem100;
  logic [6:0]  cent;
  logic [8:0]  c3;
  logic [9:0]  x25;
  logic [15:0] p25;
  logic [4:0]  gold2;
  logic [7:0]  solar2, lunar2;
  logic        leap2, err2;
  logic [13:0] y54_2;

  assign m19    = 13'(q19_1) * 13'd19;
  assign m100   = 13'(q100_1) * 13'd100;
  assign rem19  = y1 - m19;
  assign rem100 = y1 - m100;
  assign cent   = q100_1 + 7'd1;
  assign c3     = 9'(cent) * 9'd3;
  assign x25    = {cent, 3'b000} + 10'd5;
  assign p25    = 16'(x25) * 16'd41;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      gold2  <= rem19[4:0] + 5'd1;
      solar2 <= 8'(c3 >> 2) - 8'd12;
      lunar2 <= 8'(p25[15:10]) - 8'd5;
      leap2  <= (rem100 == 13'd0) ? (q100_1[1:0] == 2'd0) : (y1[1:0] == 2'd0);
      y54_2  <= 14'(y1) + 14'(y1 >> 2);
      err2   <= err1;
    end
  end

  // stage 3: epact sum before reduction, sunday term
  logic [8:0]  g11;
  logic [8:0]  esum3;
  logic [13:0] dsun3;
  logic [4:0]  gold3;
  logic        leap3, err3;

  assign g11 = 9'(gold2) * 9'd11;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      esum3 <= g11 + 9'd20 + 9'(lunar2) - 9'(solar2);
      dsun3 <= y54_2 - 14'(solar2) - 14'd10;
      gold3 <= gold2;
      leap3 <= leap2;
      err3  <= err2;
    end
  end

  // stage 4: epact mod 30 with its correction, paschal full moon
  logic [16:0] p30;
  logic [8:0]  ep;
  logic [4:0]  epact, epact_adj;
  logic [5:0]  full0;
  logic [5:0]  full4;
  logic [13:0] dsun4;
  logic        leap4, err4;

  assign p30 = 17'(esum3) * 17'd137;
  assign ep  = esum3 - 9'(p30[16:12]) * 9'd30;

  always_comb begin
    epact = ep[4:0];
    if ((epact == 5'd25 && gold3 > 5'd11) || epact == 5'd24) begin
      epact_adj = epact + 5'd1;
    end else begin
      epact_adj = epact;
    end
    full0 = 6'd44 - 6'(epact_adj);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      full4 <= (full0 < 6'd21) ? full0 + 6'd30 : full0;
      dsun4 <= dsun3;
      leap4 <= leap3;
      err4  <= err3;
    end
  end

  // stage 5: sum for the sunday search and its quotient by 7
  logic [13:0] t5_w;
  logic [27:0] p7;
  logic [13:0] t5;
  logic [11:0] q7_5;
  logic [5:0]  full5;
  logic        leap5, err5;

  assign t5_w = dsun4 + 14'(full4);
  assign p7   = 28'(t5_w) * 28'd9363;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      t5    <= t5_w;
      q7_5  <= p7[27:16];
      full5 <= full4;
      leap5 <= leap4;
      err5  <= err4;
    end
  end

  // stage 6: easter sunday, month and day of year
  logic [14:0] m7, r7w;
  logic [5:0]  f2;
  logic [4:0]  eday_w;
  logic [2:0]  emon_w;
  logic [6:0]  doy_w;
  logic [4:0]  eday6;
  logic [2:0]  emon6;
  logic [6:0]  doy6;
  logic        leap6, err6;

  assign m7  = 15'(q7_5) * 15'd7;
  assign r7w = 15'(t5) - m7;
  assign f2  = full5 + 6'd7 - 6'(r7w[2:0]);

  always_comb begin
    if (f2 > 6'd31) begin
      eday_w = 5'(f2 - 6'd31);
      emon_w = MONTH_APR;
      doy_w  = 7'd90 + 7'(leap5) + 7'(eday_w);
    end else begin
      eday_w = f2[4:0];
      emon_w = MONTH_MAR;
      doy_w  = 7'd59 + 7'(leap5) + 7'(eday_w);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      eday6 <= eday_w;
      emon6 <= emon_w;
      doy6  <= doy_w;
      leap6 <= leap5;
      err6  <= err5;
    end
  end

  // stage 7: weekday of 1 january from easter's day of year
  logic [14:0] pd;
  logic [6:0]  rd;
  logic [2:0]  r;
  logic [2:0]  wd_w;

  assign pd = 15'(doy6) * 15'd147;
  assign rd = doy6 - 7'(pd[14:10]) * 7'd7;
  assign r  = rd[2:0];

  always_comb begin
    case (r)
      3'd0:    wd_w = 3'd1;
      3'd1:    wd_w = 3'd0;
      default: wd_w = 3'(4'd8 - 4'(r));
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      res.err  <= err6;
      res.leap <= leap6;
      res.emon <= emon6;
      res.eday <= eday6;
      res.wd   <= wd_w;
    end
  end

endmodule

FILE: hdl/eamc_month_seq.sv
// month sequencer and output register, twelve results per year item
module eamc_month_seq import eamc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       res_valid,
  output logic       res_take,
  input  eamc_year_t res,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] month_number,
  output logic [2:0] first_weekday,
  output logic [4:0] month_length,
  output logic [2:0] easter_month,
  output logic [4:0] easter_day,
  output logic       leap_year,
  output logic       range_error,
  output logic       last_month
);

  logic       valid;
  logic [3:0] idx;
  logic [2:0] wd;
  eamc_year_t cur;

  logic       adv;
  logic       at_last;
  logic [4:0] len;
  logic [3:0] wsum;

  assign adv      = valid && !out_stall;
  assign at_last  = (idx == MONTHS);
  assign res_take = res_valid && (!valid || (adv && at_last));
  assign len      = month_len(idx, cur.leap);
  // len mod 7 is len - 28 for every month length
  assign wsum     = 4'(wd) + 4'(len - 5'd28);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_take) begin
      valid <= 1'b1;
    end else if (adv && at_last) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      idx <= 4'd1;
      wd  <= res.wd;
      cur <= res;
    end else if (adv && !at_last) begin
      idx <= idx + 4'd1;
      wd  <= (wsum >= 4'd7) ? 3'(wsum - 4'd7) : wsum[2:0];
    end
  end

  assign out_valid     = valid;
  assign range_error   = cur.err;
  assign month_number  = cur.err ? 4'd0 : idx;
  assign first_weekday = cur.err ? 3'd0 : wd;
  assign month_length  = cur.err ? 5'd0 : len;
  assign easter_month  = cur.err ? 3'd0 : cur.emon;
  assign easter_day    = cur.err ? 5'd0 : cur.eday;
  assign leap_year     = !cur.err && cur.leap;
  assign last_month    = !cur.err && at_last;

endmodule

FILE: hdl/eamc_checker.sv
// port level checks on the calculator output sequence, bound to the top level
module eamc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] month_number,
  input logic [4:0] month_length,
  input logic [2:0] easter_month,
  input logic       leap_year,
  input logic       range_error,
  input logic       last_month
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output item dropped while stalled");

  a_month_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !range_error && month_number != 4'd12
    |=> out_valid && month_number == $past(month_number) + 4'd1)
    else $error("months not consecutive within a year");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && !range_error |-> last_month == (month_number == 4'd12))
    else $error("last_month disagrees with month_number");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error
    |-> month_number == 4'd0 && month_length == 5'd0 && easter_month == 3'd0
        && !leap_year && !last_month)
    else $error("fields not cleared on range error");

endmodule

bind easter_and_month_weekday_calc eamc_checker u_chk (.*);
